[sv/assert_macros.svh]
// Assertion macros for the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SJWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SJWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SJWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SJWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[sv/sjws_pkg.sv]
`timescale 1ns / 1ps
package sjws_pkg;

    localparam int JOINT_COUNT   = 15;
    localparam int HISTORY_DEPTH = 16;

    localparam int JOINT_W = 4;
    localparam int POS_W   = 20;
    localparam int CONF_W  = 8;
    localparam int WIN_W   = 5;
    localparam int USED_W  = 5;

    localparam int SLOT_W      = $clog2(HISTORY_DEPTH);
    localparam int JIDX_W      = $clog2(JOINT_COUNT);
    localparam int ENTRY_COUNT = JOINT_COUNT * HISTORY_DEPTH;
    localparam int ADDR_W      = $clog2(ENTRY_COUNT);
    localparam int CNT_W       = $clog2(HISTORY_DEPTH + 1);
    localparam int DIFF_W      = POS_W + 1;
    localparam int SUM_W       = DIFF_W + SLOT_W;
    localparam int REM_W       = CNT_W + 1;
    localparam int STEP_W      = $clog2(SUM_W + 1);

    localparam int LEG_LEFT  = (9 < JOINT_COUNT - 1) ? 9 : JOINT_COUNT - 2;
    localparam int LEG_RIGHT = (12 < JOINT_COUNT) ? 12 : JOINT_COUNT - 1;

    localparam int WARM_W        = 3;
    localparam int WARMUP_FRAMES = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
    localparam int POS_MIN = -(1 << (POS_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE    = 1'b0,
        CFG_CONF_THRESHOLD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                    wr;
        logic                    fend;
        logic [JIDX_W-1:0]       joint;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CONF_W-1:0]       conf;
    } t_cmd;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CONF_W-1:0]       conf;
    } t_entry;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [JIDX_W-1:0] joint);
        return ADDR_W'(int'(slot) * JOINT_COUNT + int'(joint));
    endfunction

    function automatic logic signed [POS_W-1:0] mid_floor(input logic signed [POS_W-1:0] a,
                                                          input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] s;
        s = DIFF_W'(a) + DIFF_W'(b);
        return s[POS_W:1];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUM_W'(POS_MAX)) begin
            r = POS_W'(POS_MAX);
        end else if (v < SUM_W'(POS_MIN)) begin
            r = POS_W'(POS_MIN);
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/sjws_in_if.sv]
`timescale 1ns / 1ps
interface sjws_in_if;
    import sjws_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [JOINT_W-1:0]      joint_id;
    logic signed [POS_W-1:0] raw_x;
    logic signed [POS_W-1:0] raw_y;
    logic signed [POS_W-1:0] raw_z;
    logic [CONF_W-1:0]       confidence;
    logic                    frame_end;

    modport source(output valid, joint_id, raw_x, raw_y, raw_z, confidence, frame_end,
                   input ready);
    modport sink(input valid, joint_id, raw_x, raw_y, raw_z, confidence, frame_end,
                 output ready);
endinterface

[sv/sjws_out_if.sv]
`timescale 1ns / 1ps
interface sjws_out_if;
    import sjws_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [JOINT_W-1:0]      out_joint;
    logic signed [POS_W-1:0] avg_x;
    logic signed [POS_W-1:0] avg_y;
    logic signed [POS_W-1:0] avg_z;
    logic [USED_W-1:0]       used_count;
    logic                    last_of_frame;

    modport source(output valid, out_joint, avg_x, avg_y, avg_z, used_count, last_of_frame,
                   input ready);
    modport sink(input valid, out_joint, avg_x, avg_y, avg_z, used_count, last_of_frame,
                 output ready);
endinterface

[sv/sjws_front.sv]
`timescale 1ns / 1ps
module sjws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sjws_in_if.sink        i_in,
    output sjws_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);
    import sjws_pkg::*;

    logic r_v;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign i_in.ready  = !r_v || i_cmd_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_v;

    // Center samples and indexes past the last joint never reach the history.
    always_comb begin
        n_cmd.wr    = (i_in.joint_id != '0) && (32'(i_in.joint_id) < JOINT_COUNT);
        n_cmd.fend  = i_in.frame_end;
        n_cmd.joint = JIDX_W'(i_in.joint_id);
        n_cmd.x     = i_in.raw_x;
        n_cmd.y     = i_in.raw_y;
        n_cmd.z     = i_in.raw_z;
        n_cmd.conf  = i_in.confidence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_cmd_ready) begin
            r_v <= 1'b0;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

[sv/sjws_queue.sv]
`timescale 1ns / 1ps
module sjws_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sjws_pkg::t_cmd i_push_cmd,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    output sjws_pkg::t_cmd o_pop_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready
);
    import sjws_pkg::*;

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = r_cnt != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_cmd    = r_buf[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_buf[r_wp] <= i_push_cmd;
        end
    end
endmodule

[sv/sjws_div.sv]
`timescale 1ns / 1ps
module sjws_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [sjws_pkg::SUM_W-1:0] i_sum [3],
    input  logic [sjws_pkg::CNT_W-1:0]        i_den,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [sjws_pkg::SUM_W-1:0] o_quot [3]
);
    import sjws_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_mag [3];
    logic [REM_W-1:0]  r_rem [3];
    logic              r_neg [3];
    logic [SUM_W-1:0]  n_mag [3];
    logic [REM_W-1:0]  n_rem [3];
    logic [REM_W-1:0]  rem_s [3];
    logic              ge [3];

    assign o_busy = r_busy;
    assign o_done = r_done;

    // Restoring division of the magnitudes, one quotient bit per cycle on all axes.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rem_s[a] = {r_rem[a][REM_W-2:0], r_mag[a][SUM_W-1]};
            ge[a]    = rem_s[a] >= REM_W'(r_den);
            n_rem[a] = ge[a] ? rem_s[a] - REM_W'(r_den) : rem_s[a];
            n_mag[a] = {r_mag[a][SUM_W-2:0], ge[a]};
            o_quot[a] = r_neg[a] ? -signed'(r_mag[a]) : signed'(r_mag[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == STEP_W'(SUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_den <= i_den;
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= i_sum[a][SUM_W-1];
                r_mag[a] <= i_sum[a][SUM_W-1] ? SUM_W'(-i_sum[a]) : SUM_W'(i_sum[a]);
                r_rem[a] <= '0;
            end
        end else if (r_busy) begin
            for (int a = 0; a < 3; a++) begin
                r_mag[a] <= n_mag[a];
                r_rem[a] <= n_rem[a];
            end
        end
    end
endmodule

[sv/sjws_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sjws_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sjws_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  sjws_pkg::t_cfg_wr i_cfg,
    sjws_out_if.source        o_out
);
    import sjws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CL, S_CR, S_CW, S_CP_RD, S_CP_WR, S_SUM, S_DIV, S_EMIT
    } t_state;

    t_state                  r_state;
    logic [WARM_W-1:0]       r_warm;
    logic [SLOT_W-1:0]       r_newest;
    logic [SLOT_W-1:0]       r_target;
    logic                    r_seed;
    logic [WIN_W-1:0]        r_win;
    logic [CONF_W-1:0]       r_thr;
    logic [JIDX_W-1:0]       r_j;
    logic [SLOT_W-1:0]       r_s;
    logic [SLOT_W-1:0]       r_rslot;
    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_n;
    logic                    r_rd_v;
    logic                    r_first;
    logic signed [POS_W-1:0] r_off [3];
    logic signed [POS_W-1:0] r_lpos [3];
    logic [CONF_W-1:0]       r_lconf;
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [DIFF_W-1:0] r_ndiff [3];
    logic signed [POS_W-1:0] r_res [3];
    t_entry                  r_rd;
    t_entry                  mem [ENTRY_COUNT];

    logic                    r_out_v;
    logic [JOINT_W-1:0]      r_out_joint;
    logic signed [POS_W-1:0] r_out_pos [3];
    logic [USED_W-1:0]       r_out_used;
    logic                    r_out_last;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    t_entry                  mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;

    logic [SLOT_W-1:0]       next_slot;
    logic [SLOT_W-1:0]       target_now;
    logic [CNT_W-1:0]        w_eff;
    logic signed [POS_W-1:0] rd_pos [3];
    logic signed [POS_W-1:0] mid_pos [3];
    logic signed [DIFF_W-1:0] diff [3];
    logic                    sum_done;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot [3];
    logic                    out_free;

    assign next_slot  = (r_newest == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign target_now = (r_warm == WARM_W'(1)) ? '0 : next_slot;
    assign o_cmd_ready = r_state == S_IDLE;
    assign sum_done   = (r_k == w_eff) && !r_rd_v;
    assign div_start  = (r_state == S_SUM) && sum_done && (r_n != '0);
    assign out_free   = !r_out_v || o_out.ready;

    always_comb begin
        if (r_win == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_win) > HISTORY_DEPTH) begin
            w_eff = CNT_W'(HISTORY_DEPTH);
        end else begin
            w_eff = CNT_W'(r_win);
        end
        rd_pos[0] = r_rd.x;
        rd_pos[1] = r_rd.y;
        rd_pos[2] = r_rd.z;
        for (int a = 0; a < 3; a++) begin
            mid_pos[a] = mid_floor(r_lpos[a], rd_pos[a]);
            diff[a]    = DIFF_W'(rd_pos[a]) - DIFF_W'(r_off[a]);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_rd;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.wr && r_warm <= WARM_W'(1)) begin
                    mem_we         = 1'b1;
                    mem_waddr      = entry_addr(target_now, i_cmd.joint);
                    mem_wdata.x    = i_cmd.x;
                    mem_wdata.y    = i_cmd.y;
                    mem_wdata.z    = i_cmd.z;
                    mem_wdata.conf = i_cmd.conf;
                end
            end
            S_CL: begin
                mem_re    = 1'b1;
                mem_raddr = entry_addr(r_target, JIDX_W'(LEG_LEFT));
            end
            S_CR: begin
                mem_re    = 1'b1;
                mem_raddr = entry_addr(r_target, JIDX_W'(LEG_RIGHT));
            end
            S_CW: begin
                mem_we         = 1'b1;
                mem_waddr      = entry_addr(r_target, '0);
                mem_wdata.x    = mid_pos[0];
                mem_wdata.y    = mid_pos[1];
                mem_wdata.z    = mid_pos[2];
                mem_wdata.conf = (r_lconf < r_rd.conf) ? r_lconf : r_rd.conf;
            end
            S_CP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = entry_addr('0, r_j);
            end
            S_CP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = entry_addr(r_s, r_j);
            end
            S_SUM: begin
                mem_re    = r_k < w_eff;
                mem_raddr = entry_addr(r_rslot, r_j);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    sjws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_sum),
        .i_den   (r_n),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_warm   <= WARM_W'(WARMUP_FRAMES);
            r_newest <= '0;
            r_win    <= WIN_W'(4);
            r_thr    <= CONF_W'(128);
            r_out_v  <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_off[a] <= '0;
            end
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_WINDOW_SIZE:    r_win <= i_cfg.data[WIN_W-1:0];
                    CFG_CONF_THRESHOLD: r_thr <= i_cfg.data[CONF_W-1:0];
                    default:            r_thr <= r_thr;
                endcase
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.fend) begin
                        if (r_warm > WARM_W'(1)) begin
                            r_warm <= r_warm - 1'b1;
                        end else begin
                            r_target <= target_now;
                            r_seed   <= r_warm == WARM_W'(1);
                            r_state  <= S_CL;
                        end
                    end
                end
                S_CL: begin
                    r_state <= S_CR;
                end
                S_CR: begin
                    r_lpos[0] <= rd_pos[0];
                    r_lpos[1] <= rd_pos[1];
                    r_lpos[2] <= rd_pos[2];
                    r_lconf   <= r_rd.conf;
                    r_state   <= S_CW;
                end
                S_CW: begin
                    r_j <= '0;
                    if (r_seed) begin
                        for (int a = 0; a < 3; a++) begin
                            r_off[a] <= mid_pos[a];
                        end
                        r_state <= S_CP_RD;
                    end else begin
                        r_newest <= r_target;
                        r_rslot  <= r_target;
                        r_k      <= '0;
                        r_n      <= '0;
                        r_rd_v   <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            r_sum[a] <= '0;
                        end
                        r_state <= S_SUM;
                    end
                end
                S_CP_RD: begin
                    r_s     <= SLOT_W'(1);
                    r_state <= S_CP_WR;
                end
                S_CP_WR: begin
                    if (r_s == SLOT_W'(HISTORY_DEPTH - 1)) begin
                        if (r_j == JIDX_W'(JOINT_COUNT - 1)) begin
                            r_newest <= '0;
                            r_warm   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_CP_RD;
                        end
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_SUM: begin
                    if (r_k < w_eff) begin
                        r_k     <= r_k + 1'b1;
                        r_first <= r_k == '0;
                        r_rslot <= (r_rslot == '0) ? SLOT_W'(HISTORY_DEPTH - 1)
                                                   : r_rslot - 1'b1;
                        r_rd_v  <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v) begin
                        if (r_first) begin
                            for (int a = 0; a < 3; a++) begin
                                r_ndiff[a] <= diff[a];
                            end
                        end
                        if (r_rd.conf >= r_thr) begin
                            for (int a = 0; a < 3; a++) begin
                                r_sum[a] <= r_sum[a] + SUM_W'(diff[a]);
                            end
                            r_n <= r_n + 1'b1;
                        end
                    end
                    if (sum_done) begin
                        if (r_n == '0) begin
                            for (int a = 0; a < 3; a++) begin
                                r_res[a] <= sat_pos(SUM_W'(r_ndiff[a]));
                            end
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        for (int a = 0; a < 3; a++) begin
                            r_res[a] <= sat_pos(div_quot[a]);
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_joint <= JOINT_W'(r_j);
                        r_out_used  <= USED_W'(r_n);
                        r_out_last  <= r_j == JIDX_W'(JOINT_COUNT - 1);
                        for (int a = 0; a < 3; a++) begin
                            r_out_pos[a] <= r_res[a];
                        end
                        if (r_j == JIDX_W'(JOINT_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_rslot <= r_newest;
                            r_k     <= '0;
                            r_n     <= '0;
                            r_rd_v  <= 1'b0;
                            for (int a = 0; a < 3; a++) begin
                                r_sum[a] <= '0;
                            end
                            r_state <= S_SUM;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.out_joint     = r_out_joint;
    assign o_out.avg_x         = r_out_pos[0];
    assign o_out.avg_y         = r_out_pos[1];
    assign o_out.avg_z         = r_out_pos[2];
    assign o_out.used_count    = r_out_used;
    assign o_out.last_of_frame = r_out_last;

    `SJWS_ASSERT_NEVER(a_slot_range, i_clk, i_rst_n, r_newest > SLOT_W'(HISTORY_DEPTH - 1), "bad slot")
    `SJWS_ASSERT(a_div_idle, i_clk, i_rst_n, div_start |-> !div_busy, "divider restarted")
    `SJWS_ASSERT(a_used_le_win, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_n <= w_eff), "count too big")
    `SJWS_ASSERT(a_no_warm_emit, i_clk, i_rst_n, (r_warm != '0) |-> !r_out_v, "result during warmup")
endmodule

[sv/skeleton_joint_window_smoother_core.sv]
`timescale 1ns / 1ps
// A sample item passes the front register and the queue, then the back end stores it while idle.
// A frame end after warmup emits JOINT_COUNT results; each joint's time is set by
// one history read per cycle and a 25-step serial divider, skipped when no sample meets the threshold.
// The seeding frame end copies slot zero over the ring and emits no results.
// Synchronous active-low reset restores window 4, threshold 128 and a four-frame warmup.
module skeleton_joint_window_smoother_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sjws_in_if.sink                          i_in,
    sjws_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [sjws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sjws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sjws_pkg::*;

    t_cmd    f_cmd;
    logic    f_valid;
    logic    f_ready;
    t_cmd    q_cmd;
    logic    q_valid;
    logic    q_ready;
    t_cfg_wr cfg;

    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = t_cfg_idx'(i_cfg_idx);
        cfg.data = i_cfg_data;
    end

    sjws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready)
    );

    sjws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (f_cmd),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .o_pop_cmd    (q_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready)
    );

    sjws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cfg       (cfg),
        .o_out       (o_out)
    );
endmodule

[verif/skeleton_joint_window_smoother_checker.sv]
`timescale 1ns / 1ps
module skeleton_joint_window_smoother_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sjws_in_if                              i_in_mon,
    sjws_out_if                             i_out_mon,
    input  logic                            i_cfg_we,
    input  logic [sjws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sjws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sjws_pkg::*;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [USED_W-1:0]       used;
        logic                    last;
    } t_smoothed;

    t_smoothed         smoothed_q[$];
    t_entry            hist[HISTORY_DEPTH][JOINT_COUNT];
    longint            zoff[3];
    logic [WIN_W-1:0]  win_size;
    logic [CONF_W-1:0] conf_thr;
    int                warm;
    int                newest;
    int                fail_count;

    assign o_fail_count = fail_count;

    initial fail_count = 0;

    function automatic longint pos_axis(t_entry e, int a);
        return (a == 0) ? longint'(e.x) : (a == 1) ? longint'(e.y) : longint'(e.z);
    endfunction

    function automatic longint sat_axis(longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    task automatic set_center(int slot);
        t_entry l;
        t_entry r;
        l = hist[slot][LEG_LEFT];
        r = hist[slot][LEG_RIGHT];
        hist[slot][0].x = POS_W'((longint'(l.x) + longint'(r.x)) >>> 1);
        hist[slot][0].y = POS_W'((longint'(l.y) + longint'(r.y)) >>> 1);
        hist[slot][0].z = POS_W'((longint'(l.z) + longint'(r.z)) >>> 1);
        hist[slot][0].conf = (l.conf < r.conf) ? l.conf : r.conf;
    endtask

    task automatic absorb_sample();
        int        tgt;
        int        j;
        int        w;
        int        slot;
        longint    sum[3];
        int        n;
        t_smoothed res;
        j = int'(i_in_mon.joint_id);
        tgt = (warm == 1) ? 0 : (newest + 1) % HISTORY_DEPTH;
        if (warm <= 1 && j != 0 && j < JOINT_COUNT) begin
            hist[tgt][j] = '{i_in_mon.raw_x, i_in_mon.raw_y, i_in_mon.raw_z,
                             i_in_mon.confidence};
        end
        if (!i_in_mon.frame_end) return;
        if (warm > 1) begin
            warm--;
            return;
        end
        if (warm == 1) begin
            for (int a = 0; a < 3; a++) begin
                zoff[a] = (pos_axis(hist[0][LEG_LEFT], a) + pos_axis(hist[0][LEG_RIGHT], a))
                          >>> 1;
            end
            set_center(0);
            for (int s = 1; s < HISTORY_DEPTH; s++) hist[s] = hist[0];
            newest = 0;
            warm = 0;
            return;
        end
        set_center(tgt);
        newest = tgt;
        w = int'(win_size);
        if (w < 1) w = 1;
        if (w > HISTORY_DEPTH) w = HISTORY_DEPTH;
        for (int jj = 0; jj < JOINT_COUNT; jj++) begin
            sum = '{0, 0, 0};
            n = 0;
            for (int k = 0; k < w; k++) begin
                slot = (newest + HISTORY_DEPTH - k) % HISTORY_DEPTH;
                if (hist[slot][jj].conf >= conf_thr) begin
                    for (int a = 0; a < 3; a++) sum[a] += pos_axis(hist[slot][jj], a) - zoff[a];
                    n++;
                end
            end
            for (int a = 0; a < 3; a++) begin
                if (n == 0) sum[a] = pos_axis(hist[newest][jj], a) - zoff[a];
                else sum[a] = sum[a] / n;
            end
            res.joint = JOINT_W'(jj);
            res.x = POS_W'(sat_axis(sum[0]));
            res.y = POS_W'(sat_axis(sum[1]));
            res.z = POS_W'(sat_axis(sum[2]));
            res.used = USED_W'(n);
            res.last = (jj == JOINT_COUNT - 1);
            smoothed_q.push_back(res);
        end
    endtask

    task automatic report(string field, longint want, longint got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endtask

    task automatic compare_result();
        t_smoothed want;
        if (smoothed_q.size() == 0) begin
            report("unexpected item, joint", -1, i_out_mon.out_joint);
            return;
        end
        want = smoothed_q.pop_front();
        if (i_out_mon.out_joint !== want.joint) report("out_joint", want.joint,
                                                        i_out_mon.out_joint);
        if (i_out_mon.avg_x !== want.x) report("avg_x", want.x, i_out_mon.avg_x);
        if (i_out_mon.avg_y !== want.y) report("avg_y", want.y, i_out_mon.avg_y);
        if (i_out_mon.avg_z !== want.z) report("avg_z", want.z, i_out_mon.avg_z);
        if (i_out_mon.used_count !== want.used) report("used_count", want.used,
                                                        i_out_mon.used_count);
        if (i_out_mon.last_of_frame !== want.last) report("last_of_frame", want.last,
                                                          i_out_mon.last_of_frame);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_size = WIN_W'(4);
            conf_thr = CONF_W'(128);
            warm = WARMUP_FRAMES;
            newest = 0;
            zoff = '{0, 0, 0};
            for (int s = 0; s < HISTORY_DEPTH; s++) begin
                for (int j = 0; j < JOINT_COUNT; j++) hist[s][j] = '0;
            end
            smoothed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW_SIZE: begin
                        win_size = i_cfg_data[WIN_W-1:0];
                    end
                    CFG_CONF_THRESHOLD: begin
                        conf_thr = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) absorb_sample();
            if (i_out_mon.valid && i_out_mon.ready) compare_result();
        end
        o_pending <= smoothed_q.size();
    end

endmodule

[verif/skeleton_joint_window_smoother_core_tb.sv]
`timescale 1ns / 1ps
module skeleton_joint_window_smoother_core_tb;
    import sjws_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    idle_en;
    int                    stall_left = 0;
    logic [CONF_W-1:0]     cur_thr;

    sjws_in_if  in_ch();
    sjws_out_if out_ch();

    skeleton_joint_window_smoother_core dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    skeleton_joint_window_smoother_checker smoothing_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return POS_W'(POS_MAX);
            1: return POS_W'(POS_MIN);
            2, 3: return POS_W'($signed($urandom_range(0, 8000)) - 4000);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [CONF_W-1:0] rand_conf();
        case ($urandom_range(0, 5))
            0: return CONF_W'(255);
            1: return CONF_W'(0);
            2: return cur_thr;
            3: return cur_thr - CONF_W'(1);
            default: return CONF_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(logic [JOINT_W-1:0] joint, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                               logic [CONF_W-1:0] conf, logic fend);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.joint_id <= joint;
        in_ch.raw_x <= x;
        in_ch.raw_y <= y;
        in_ch.raw_z <= z;
        in_ch.confidence <= conf;
        in_ch.frame_end <= fend;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // A broken frame drops more joints and mixes in center, out-of-range and repeated samples.
    task automatic send_frame(bit broken);
        int order[$];
        int tmp;
        int pick;
        logic [JOINT_W-1:0] jt;
        for (int j = 1; j < JOINT_COUNT; j++) begin
            if ($urandom_range(0, broken ? 2 : 9) != 0) order.push_back(j);
        end
        for (int i = order.size() - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        if (broken || $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0: order.insert($urandom_range(0, order.size()), 0);
                    1: order.insert($urandom_range(0, order.size()), 15);
                    default: order.insert($urandom_range(0, order.size()),
                                          $urandom_range(1, JOINT_COUNT - 1));
                endcase
            end
        end
        if (order.size() == 0) order.push_back($urandom_range(0, 15));
        foreach (order[i]) begin
            jt = JOINT_W'(order[i]);
            send_sample(jt, rand_pos(), rand_pos(), rand_pos(), rand_conf(),
                        i == order.size() - 1);
        end
    endtask

    task automatic uniform_frame(logic signed [POS_W-1:0] p, logic [CONF_W-1:0] conf);
        for (int j = 1; j < JOINT_COUNT; j++) begin
            send_sample(JOINT_W'(j), p, p, p, conf, j == JOINT_COUNT - 1);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CONF_THRESHOLD) cur_thr = value;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] win_list[6];
        logic [CFG_DATA_W-1:0] thr_list[6];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_WINDOW_SIZE;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.joint_id <= '0;
        in_ch.raw_x <= '0;
        in_ch.raw_y <= '0;
        in_ch.raw_z <= '0;
        in_ch.confidence <= '0;
        in_ch.frame_end <= 1'b0;
        idle_en = 1'b1;
        cur_thr = CONF_W'(128);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_WINDOW_SIZE, 8'd1);
        write_reg(CFG_CONF_THRESHOLD, 8'd255);

        send_frame(1'b1);
        send_frame(1'b0);
        send_sample(JOINT_W'(15), rand_pos(), rand_pos(), rand_pos(), rand_conf(), 1'b1);

        // The seeding frame sends every joint; the legs pin the offset per axis so that
        // later averages saturate high on y and z and low on x.
        for (int j = 1; j < JOINT_COUNT; j++) begin
            if (j == LEG_LEFT) begin
                send_sample(JOINT_W'(j), POS_W'(POS_MAX), POS_W'(POS_MIN), POS_W'(POS_MAX),
                            8'd255, 1'b0);
            end else if (j == LEG_RIGHT) begin
                send_sample(JOINT_W'(j), POS_W'(POS_MAX), POS_W'(POS_MIN), POS_W'(POS_MIN),
                            8'd200, 1'b0);
            end else begin
                send_sample(JOINT_W'(j), rand_pos(), rand_pos(), rand_pos(), rand_conf(),
                            j == JOINT_COUNT - 1);
            end
        end
        uniform_frame(POS_W'(POS_MAX), 8'd255);
        uniform_frame(POS_W'(POS_MIN), 8'd0);
        send_frame(1'b1);
        settle();

        win_list = '{8'd16, 8'd0, 8'd31, 8'd4, 8'($urandom_range(0, 31)), 8'd2};
        thr_list = '{8'd0, 8'd128, 8'd200, 8'($urandom), 8'd255, 8'd1};
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_WINDOW_SIZE, win_list[p]);
            write_reg(CFG_CONF_THRESHOLD, thr_list[p]);
            for (int f = 0; f < 3; f++) begin
                idle_en = (p < 5) && ($urandom_range(0, 2) != 0);
                send_frame($urandom_range(0, 4) == 0);
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("skeleton_joint_window_smoother_core regression: pass");
        end else begin
            $display("skeleton_joint_window_smoother_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("skeleton_joint_window_smoother_core regression: fail");
        $finish;
    end

endmodule
